FILE: src/mmdc_pkg.sv
// Shared types, register map and helper functions for the delta codec.
`default_nettype none

package mmdc_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned BW_W     = 6;
    localparam int unsigned ADDR_W   = 4;
    localparam int unsigned APB_W    = 32;
    localparam int unsigned OUT_DW   = 40;

    typedef enum logic [1:0] {
        MODE_DELTA  = 2'd0,
        MODE_ZIGZAG = 2'd1,
        MODE_XOR    = 2'd2,
        MODE_XOR_ALT = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        REG_MODE      = 2'd0,
        REG_DIRECTION = 2'd1,
        REG_START     = 2'd2,
        REG_MIN_DELTA = 2'd3
    } t_reg_idx;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    typedef struct packed {
        t_mode              mode;
        logic               direction;
        logic [WORD_W-1:0]  start_value;
        logic [WORD_W-1:0]  min_delta;
    } t_cfg;

    // Count of bits up to and including the highest set bit, 0 for zero.
    function automatic logic [BW_W-1:0] bits_needed(input logic [WORD_W-1:0] v);
        logic [BW_W-1:0] n;
        n = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (v[i]) begin
                n = BW_W'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

FILE: src/mmdc_xform.sv
// Per-beat transform: delta, zigzag delta or xor, encode or decode.
`default_nettype none

module mmdc_xform
    import mmdc_pkg::*;
(
    input  var t_cfg              i_cfg,
    input  wire [WORD_W-1:0]      i_word,
    input  wire [WORD_W-1:0]      i_pred,
    input  wire [WORD_W-1:0]      i_or_base,
    output logic [WORD_W-1:0]     o_result,
    output logic [WORD_W-1:0]     o_or_next,
    output logic [BW_W-1:0]       o_bit_width
);

    logic [WORD_W-1:0] diff;
    logic [WORD_W-1:0] zz_enc;
    logic [WORD_W-1:0] zz_dec;

    assign diff   = i_word - i_pred;
    assign zz_enc = {diff[WORD_W-2:0], 1'b0} ^ {WORD_W{diff[WORD_W-1]}};
    assign zz_dec = {1'b0, i_word[WORD_W-1:1]} ^ {WORD_W{i_word[0]}};

    always_comb begin
        if (i_cfg.direction == DIR_ENCODE) begin
            case (i_cfg.mode)
                MODE_DELTA:  o_result = diff - i_cfg.min_delta;
                MODE_ZIGZAG: o_result = zz_enc;
                default:     o_result = i_word ^ i_pred;
            endcase
        end else begin
            case (i_cfg.mode)
                MODE_DELTA:  o_result = i_pred + i_word + i_cfg.min_delta;
                MODE_ZIGZAG: o_result = i_pred + zz_dec;
                default:     o_result = i_word ^ i_pred;
            endcase
        end
    end

    // Decode leaves the packing accumulator alone and reports zero width.
    always_comb begin
        if (i_cfg.direction == DIR_ENCODE) begin
            o_or_next   = i_or_base | o_result;
            o_bit_width = bits_needed(o_or_next);
        end else begin
            o_or_next   = i_or_base;
            o_bit_width = '0;
        end
    end

endmodule

`default_nettype wire

FILE: src/multi_mode_delta_codec.sv
// Top level of the multi-mode delta codec: config port, state and output stage.
`default_nettype none

// Streaming delta codec. Each 32-bit beat on s_axis is transformed against the
// previous raw word of its block (or start_value for the first beat after reset
// or after a beat with tlast set): mode 0 subtracts the predecessor and
// min_delta, mode 1 zigzag-maps the signed difference, mode 2 (and 3) xors with
// the predecessor; direction selects encode or decode, all modulo 2^32. While
// encoding, each result also carries the packing width of the block so far
// (highest set bit of the OR of its encoded words, 0 when that OR is 0); decode
// reports 0. Throughput is one beat per clock while the output is not stalled:
// the transform and width count sit between the input handshake and a single
// output register, and s_axis_tready stays high while that register is empty or
// being drained. Registers sit on an APB port at byte addresses 0x0 mode,
// 0x4 direction, 0x8 start_value, 0xC min_delta; write them only while idle.
// pready is tied high and reads return the stored value.

module multi_mode_delta_codec
    import mmdc_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    // APB configuration
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire [ADDR_W-1:0]    paddr,
    input  wire [APB_W-1:0]     pwdata,
    output logic [APB_W-1:0]    prdata,
    output logic                pready,
    // input stream
    input  wire                 s_axis_tvalid,
    output logic                s_axis_tready,
    input  wire [WORD_W-1:0]    s_axis_tdata,   // [31:0] word
    input  wire                 s_axis_tlast,   // last
    // result stream
    output logic                m_axis_tvalid,
    input  wire                 m_axis_tready,
    output logic [OUT_DW-1:0]   m_axis_tdata,   // [31:0] result, [37:32] bit_width, [39:38] 0
    output logic                m_axis_tlast    // result_last
);

    t_cfg               r_cfg;
    logic [WORD_W-1:0]  r_prev;
    logic               r_fresh;
    logic [WORD_W-1:0]  r_or;
    logic               r_out_valid;
    logic [WORD_W-1:0]  r_out_result;
    logic [BW_W-1:0]    r_out_bw;
    logic               r_out_last;

    logic               cfg_wr;
    t_reg_idx           cfg_idx;
    logic               in_beat;
    logic [WORD_W-1:0]  pred;
    logic [WORD_W-1:0]  or_base;
    logic [WORD_W-1:0]  xf_result;
    logic [WORD_W-1:0]  xf_or_next;
    logic [BW_W-1:0]    xf_bw;

    // ---------------- configuration ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode        <= MODE_DELTA;
            r_cfg.direction   <= DIR_ENCODE;
            r_cfg.start_value <= '0;
            r_cfg.min_delta   <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_MODE:      r_cfg.mode        <= t_mode'(pwdata[1:0]);
                REG_DIRECTION: r_cfg.direction   <= pwdata[0];
                REG_START:     r_cfg.start_value <= pwdata[WORD_W-1:0];
                REG_MIN_DELTA: r_cfg.min_delta   <= pwdata[WORD_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_MODE:      prdata = {{(APB_W-2){1'b0}}, r_cfg.mode};
            REG_DIRECTION: prdata = {{(APB_W-1){1'b0}}, r_cfg.direction};
            REG_START:     prdata = r_cfg.start_value;
            REG_MIN_DELTA: prdata = r_cfg.min_delta;
            default:       prdata = '0;
        endcase
    end

    // ---------------- datapath ----------------
    // Accept while the output register is empty or emptying this cycle.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    // A fresh block starts from start_value with a cleared accumulator.
    assign pred    = r_fresh ? r_cfg.start_value : r_prev;
    assign or_base = r_fresh ? '0 : r_or;

    mmdc_xform u_xform (
        .i_cfg       (r_cfg),
        .i_word      (s_axis_tdata),
        .i_pred      (pred),
        .i_or_base   (or_base),
        .o_result    (xf_result),
        .o_or_next   (xf_or_next),
        .o_bit_width (xf_bw)
    );

    // Advance block state on every accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_fresh <= 1'b1;
            r_or    <= '0;
        end else if (in_beat) begin
            r_prev  <= (r_cfg.direction == DIR_ENCODE) ? s_axis_tdata : xf_result;
            r_fresh <= s_axis_tlast;
            r_or    <= xf_or_next;
        end
    end

    // Output register: load on accept, drop valid once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_beat) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_out_result <= xf_result;
            r_out_bw     <= xf_bw;
            r_out_last   <= s_axis_tlast;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DW-WORD_W-BW_W){1'b0}}, r_out_bw, r_out_result};
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

FILE: src/mmdc_checker.sv
// Port-level checks for the delta codec, bound to the top level.
`default_nettype none

module mmdc_port_checker
    import mmdc_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 pready,
    input  wire                 s_axis_tvalid,
    input  wire                 s_axis_tready,
    input  wire                 m_axis_tvalid,
    input  wire                 m_axis_tready,
    input  wire [OUT_DW-1:0]    m_axis_tdata,
    input  wire                 m_axis_tlast
);

    // A stalled result beat holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
        else $error("result beat changed while stalled");

    // An empty output stage never backpressures the input.
    a_no_stall_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output stage");

    // Every accepted input beat shows up as a result on the next cycle.
    a_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted beat did not produce a result");

    // Packing width never exceeds the word width.
    a_bw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[WORD_W+BW_W-1:WORD_W] <= BW_W'(WORD_W))
        else $error("bit width out of range");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready && $stable(pready))
        else $error("pready dropped");

endmodule

bind multi_mode_delta_codec mmdc_port_checker u_mmdc_port_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

FILE: dv/mmdc_checker.sv
// Result checker for the delta codec: tracks register writes, predicts every result beat, compares.
`timescale 1ns / 100ps

module mmdc_checker
    import mmdc_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_psel,
    input  wire                 i_penable,
    input  wire                 i_pwrite,
    input  wire [ADDR_W-1:0]    i_paddr,
    input  wire [APB_W-1:0]     i_pwdata,
    input  wire                 i_pready,
    input  wire                 i_s_tvalid,
    input  wire                 i_s_tready,
    input  wire [WORD_W-1:0]    i_s_tdata,     // [31:0] word
    input  wire                 i_s_tlast,     // last
    input  wire                 i_m_tvalid,
    input  wire                 i_m_tready,
    input  wire [OUT_DW-1:0]    i_m_tdata,     // [31:0] result, [37:32] bit_width, [39:38] 0
    input  wire                 i_m_tlast,     // result_last
    output int                  o_errors,
    output int                  o_pending,
    output int                  o_words_in,
    output int                  o_words_out
);

    typedef struct packed {
        logic [WORD_W-1:0]  value;
        logic [BW_W-1:0]    width;
        logic               last;
    } t_coded;

    t_mode              cfg_mode;
    logic               cfg_dir;
    logic [WORD_W-1:0]  cfg_start;
    logic [WORD_W-1:0]  cfg_min;

    logic [WORD_W-1:0]  prev_raw;
    logic [WORD_W-1:0]  or_acc;
    logic               fresh;

    t_coded             coded_q[$];
    int                 errors;
    int                 words_in;
    int                 words_out;

    // Work out the coded beat for one input word and advance the codec state.
    function automatic t_coded code_word(input logic [WORD_W-1:0] w, input logic l);
        logic [WORD_W-1:0] pred;
        logic [WORD_W-1:0] diff;
        logic [WORD_W-1:0] r;
        t_coded            c;
        pred = fresh ? cfg_start : prev_raw;
        if (fresh) begin
            or_acc = '0;
        end
        c.width = '0;
        if (cfg_dir == DIR_ENCODE) begin
            case (cfg_mode)
                MODE_DELTA: begin
                    r = w - pred - cfg_min;
                end
                MODE_ZIGZAG: begin
                    diff = w - pred;
                    r = {diff[WORD_W-2:0], 1'b0} ^ {WORD_W{diff[WORD_W-1]}};
                end
                default: begin
                    r = w ^ pred;
                end
            endcase
            prev_raw = w;
            or_acc = or_acc | r;
            for (int b = 0; b < WORD_W; b++) begin
                if (or_acc[b]) begin
                    c.width = BW_W'(b + 1);
                end
            end
        end else begin
            case (cfg_mode)
                MODE_DELTA: begin
                    r = pred + w + cfg_min;
                end
                MODE_ZIGZAG: begin
                    r = pred + ({1'b0, w[WORD_W-1:1]} ^ {WORD_W{w[0]}});
                end
                default: begin
                    r = w ^ pred;
                end
            endcase
            prev_raw = r;
        end
        c.value = r;
        c.last = l;
        fresh = l;
        return c;
    endfunction

    always @(posedge i_clk) begin : track
        t_coded exp_c;
        if (!i_rst_n) begin
            cfg_mode = MODE_DELTA;
            cfg_dir = DIR_ENCODE;
            cfg_start = '0;
            cfg_min = '0;
            prev_raw = '0;
            or_acc = '0;
            fresh = 1'b1;
            coded_q.delete();
            errors = 0;
            words_in = 0;
            words_out = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[3:2]))
                    REG_MODE:      cfg_mode = t_mode'(i_pwdata[1:0]);
                    REG_DIRECTION: cfg_dir = i_pwdata[0];
                    REG_START:     cfg_start = i_pwdata[WORD_W-1:0];
                    REG_MIN_DELTA: cfg_min = i_pwdata[WORD_W-1:0];
                    default: ;
                endcase
            end
            // results first, so a beat cannot match a word taken at the same edge
            if (i_m_tvalid && i_m_tready) begin
                words_out++;
                if (coded_q.size() == 0) begin
                    errors++;
                    $display("%0t: result beat %h (last %b) with nothing expected",
                             $time, i_m_tdata, i_m_tlast);
                end else begin
                    exp_c = coded_q.pop_front();
                    if (i_m_tdata[WORD_W-1:0] !== exp_c.value) begin
                        errors++;
                        $display("%0t: result expected %h actual %h",
                                 $time, exp_c.value, i_m_tdata[WORD_W-1:0]);
                    end
                    if (i_m_tdata[WORD_W +: BW_W] !== exp_c.width) begin
                        errors++;
                        $display("%0t: bit_width expected %0d actual %0d",
                                 $time, exp_c.width, i_m_tdata[WORD_W +: BW_W]);
                    end
                    if (i_m_tlast !== exp_c.last) begin
                        errors++;
                        $display("%0t: result_last expected %b actual %b",
                                 $time, exp_c.last, i_m_tlast);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                words_in++;
                coded_q.push_back(code_word(i_s_tdata, i_s_tlast));
            end
        end
        o_errors <= errors;
        o_pending <= coded_q.size();
        o_words_in <= words_in;
        o_words_out <= words_out;
    end

endmodule

FILE: dv/multi_mode_delta_codec_tb.sv
// Testbench top for the delta codec: clock, reset, register writes, word stimulus and verdict.
`timescale 1ns / 100ps

module multi_mode_delta_codec_tb;
    import mmdc_pkg::*;

    localparam int N_RANDOM    = 750;   // random words after the directed part
    localparam int HOLD_CYCLES = 300;   // long output stall to back the block up
    localparam int QUIET_LIMIT = 5000;  // cycles with no beat and no register access

    logic               clk;
    logic               rst_n;

    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [APB_W-1:0]   pwdata;
    logic [APB_W-1:0]   prdata;
    logic               pready;

    logic               s_tvalid;
    logic               s_tready;
    logic [WORD_W-1:0]  s_tdata;    // [31:0] word
    logic               s_tlast;    // last

    logic               m_tvalid;
    logic               m_tready;
    logic [OUT_DW-1:0]  m_tdata;    // [31:0] result, [37:32] bit_width, [39:38] 0
    logic               m_tlast;    // result_last

    int                 errors;
    int                 pending;
    int                 words_in;
    int                 words_out;

    int                 tx_idle_pct = 20;
    int                 rx_idle_pct = 20;
    int                 hold_req = 0;
    int                 quiet = 0;
    int                 settings = 0;
    logic [WORD_W-1:0]  last_raw = '0;

    multi_mode_delta_codec dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tlast  (s_tlast),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tlast  (m_tlast)
    );

    mmdc_checker results_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .i_pready    (pready),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tlast   (s_tlast),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tlast   (m_tlast),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_words_in  (words_in),
        .o_words_out (words_out)
    );

    // 2 ns clock
    initial clk = 1'b0;
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet >= QUIET_LIMIT) begin
            $display("multi_mode_delta_codec_tb: errors");
            $finish;
        end
    end

    // Result sink: drop tready at random, and hold it low for a long stretch
    // whenever the stimulus asks for one.
    initial begin : sink
        int hold_seen;
        hold_seen = 0;
        m_tready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Pick a corner value most of the time, a random one otherwise.
    function automatic logic [WORD_W-1:0] pick_corner();
        case ($urandom_range(4))
            0:       return '0;
            1:       return '1;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Register write: setup phase, access phase, then an idle phase so that
    // back-to-back writes never drive psel twice in one step.
    task automatic apb_write(input t_reg_idx idx, input logic [APB_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one word beat, idling first at random; return at the accepting
    // edge with tvalid still high so the next beat can follow directly.
    task automatic send_word(input logic [WORD_W-1:0] w, input logic l);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= w;
        s_tlast <= l;
        last_raw = w;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // Drop tvalid and wait until every predicted result has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    initial begin : stimulus
        int                sent;
        int                n_items;
        int                block_left;
        logic [WORD_W-1:0] w;
        logic              l;

        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        sent = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. Run first on the reset values: delta encode,
        // start 0, min_delta 0, so wrap-around and the top bit show up.
        settings++;
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h0000_0001, 1'b1);
        send_word(32'h7FFF_FFFF, 1'b0);
        send_word(32'h0000_0000, 1'b1);

        // Zigzag encode from an all-ones start; min_delta must be ignored.
        drain_results();
        apb_write(REG_MODE, APB_W'(MODE_ZIGZAG));
        apb_write(REG_START, 32'hFFFF_FFFF);
        apb_write(REG_MIN_DELTA, 32'h1234_5678);
        settings++;
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h7FFF_FFFF, 1'b1);

        // Unused mode code 3 decodes as xor.
        drain_results();
        apb_write(REG_MODE, APB_W'(MODE_XOR_ALT));
        apb_write(REG_DIRECTION, APB_W'(DIR_DECODE));
        apb_write(REG_START, 32'hA5A5_A5A5);
        settings++;
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b1);

        // Delta decode with the largest min_delta.
        drain_results();
        apb_write(REG_MODE, APB_W'(MODE_DELTA));
        apb_write(REG_MIN_DELTA, 32'hFFFF_FFFF);
        apb_write(REG_START, 32'h0000_0000);
        settings++;
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h8000_0000, 1'b1);

        // Zigzag decode: odd and even codes, both extremes.
        drain_results();
        apb_write(REG_MODE, APB_W'(MODE_ZIGZAG));
        apb_write(REG_START, 32'h8000_0000);
        settings++;
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h0000_0001, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'hFFFF_FFFE, 1'b1);

        // Xor encode: zero width while the OR stays 0, then a one-word
        // block that must clear the OR and report the full width.
        drain_results();
        apb_write(REG_MODE, APB_W'(MODE_XOR));
        apb_write(REG_DIRECTION, APB_W'(DIR_ENCODE));
        apb_write(REG_START, 32'h0000_0000);
        settings++;
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h0000_0001, 1'b1);
        send_word(32'h8000_0000, 1'b1);

        // Change registers in the middle of a block: the predecessor is kept.
        send_word(32'h1234_5678, 1'b0);
        drain_results();
        apb_write(REG_MODE, APB_W'(MODE_DELTA));
        apb_write(REG_MIN_DELTA, 32'h0000_0000);
        settings++;
        send_word(32'h1234_5679, 1'b1);

        // Random part: a fresh register setting per phase, blocks of random
        // length, words that mostly stay close to the previous one so that
        // encoded widths vary. A phase may end mid-block.
        while (sent < N_RANDOM) begin
            drain_results();
            if ($urandom_range(1)) begin
                apb_write(REG_MODE, $urandom_range(3));
            end
            if ($urandom_range(1)) begin
                apb_write(REG_DIRECTION, $urandom_range(1));
            end
            if ($urandom_range(1)) begin
                apb_write(REG_START, pick_corner());
            end
            if ($urandom_range(1)) begin
                apb_write(REG_MIN_DELTA, pick_corner());
            end
            settings++;

            // Third setting: stall the sink long enough to fill the block.
            // Fifth setting: no idling on either side.
            if (settings == 10) begin
                hold_req <= hold_req + 1;
            end
            if (settings == 12) begin
                tx_idle_pct = 0;
                rx_idle_pct <= 0;
                n_items = 80;
            end else begin
                tx_idle_pct = 20;
                rx_idle_pct <= 20;
                n_items = (settings == 10) ? 50 : $urandom_range(10, 50);
            end

            block_left = $urandom_range(1, 8);
            for (int i = 0; i < n_items; i++) begin
                case ($urandom_range(3))
                    0:       w = $urandom();
                    1:       w = last_raw + ($urandom_range(64) - 32);
                    2:       w = last_raw ^ (32'h1 << $urandom_range(31));
                    default: w = pick_corner();
                endcase
                block_left--;
                l = (i == n_items - 1) ? 1'($urandom_range(1)) : (block_left == 0);
                if (block_left == 0) begin
                    block_left = ($urandom_range(9) == 0) ? $urandom_range(20, 40)
                                                          : $urandom_range(1, 8);
                end
                send_word(w, l);
                sent++;
            end
        end

        // Let the last results drain, then wait for any strays.
        drain_results();
        repeat (4) @(posedge clk);

        $display("summary: %0d words in, %0d results out, %0d register settings",
                 words_in, words_out, settings);
        $display("summary: all mode codes both ways, block restarts, mid-block writes, long stall");
        if (errors == 0) begin
            $display("multi_mode_delta_codec_tb: clean");
        end else begin
            $display("multi_mode_delta_codec_tb: errors");
        end
        $finish;
    end

endmodule
